// ===== rtl/ssc_pkg.sv =====
// Shared types, constants and the microcode program of the search stop controller
package ssc_pkg;

	typedef enum logic [1:0] {
		CMD_QUIET   = 2'd0,
		CMD_REPLACE = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	localparam logic [2:0] CFG_BETA_M    = 3'd0;
	localparam logic [2:0] CFG_BETA_S    = 3'd1;
	localparam logic [2:0] CFG_THRESHOLD = 3'd2;
	localparam logic [2:0] CFG_TOPK      = 3'd3;
	localparam logic [2:0] CFG_FLOOR     = 3'd4;
	localparam logic [2:0] CFG_QLIMIT    = 3'd5;

	localparam logic [15:0] RST_BETA_M    = 16'd58982;
	localparam logic [15:0] RST_BETA_S    = 16'd64881;
	localparam logic [31:0] RST_THRESHOLD = 32'd42949673;
	localparam logic [8:0]  RST_TOPK      = 9'd10;
	localparam logic [31:0] RST_FLOOR     = 32'd1;
	localparam logic [15:0] RST_QLIMIT    = 16'd10000;

	localparam logic [31:0] BPOW_ONE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] beta_m;
		logic [15:0] beta_s;
		logic [31:0] threshold;
		logic [8:0]  topk;
		logic [31:0] dist_floor;
		logic [15:0] qlimit;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOADA,
		OP_LOADB,
		OP_NORM16,
		OP_NORM8,
		OP_NORM4,
		OP_NORM2,
		OP_NORM1,
		OP_SQR,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_GAIN_BPOW,
		OP_QUIET_BPOW,
		OP_MOM_LO,
		OP_MOM_GAIN,
		OP_MOM_HI,
		OP_SCL_LO,
		OP_SCL_HI,
		OP_SCL_MAX,
		OP_T_CALC,
		OP_CMP_LO,
		OP_CMP_HI,
		OP_CMP_FIN,
		OP_QLIM,
		OP_RESTART,
		OP_ERR
	} op_t;

	typedef enum logic [3:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_QUIET,
		COND_RESTART,
		COND_UNUSED,
		COND_BADORD,
		COND_LOOP,
		COND_GZERO,
		COND_SCLZERO
	} cond_t;

	localparam int UCODE_LEN = 41;
	localparam int PC_W      = $clog2(UCODE_LEN);

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		logic  done;
	} uword_t;

	typedef struct packed {
		logic start;
		logic en;
		op_t  op;
	} ctl_t;

	typedef struct packed {
		logic cmd_quiet;
		logic cmd_restart;
		logic cmd_unused;
		logic bad_order;
		logic loop_more;
		logic gain_zero;
		logic scale_zero;
	} flags_t;

	typedef struct packed {
		logic stop;
		logic error;
	} res_t;

	localparam pc_t A_NONE  = pc_t'(0);
	localparam pc_t A_SQRA  = pc_t'(10);
	localparam pc_t A_SQRB  = pc_t'(17);
	localparam pc_t A_DIV   = pc_t'(19);
	localparam pc_t A_QUIET = pc_t'(27);
	localparam pc_t A_STEST = pc_t'(33);
	localparam pc_t A_QLIM  = pc_t'(37);
	localparam pc_t A_RST   = pc_t'(38);
	localparam pc_t A_IGN   = pc_t'(39);
	localparam pc_t A_ERR   = pc_t'(40);

	localparam uword_t UCODE [UCODE_LEN] = '{
		// dispatch on event kind
		'{OP_NOP,        COND_QUIET,   A_QUIET, 1'b0},
		'{OP_NOP,        COND_RESTART, A_RST,   1'b0},
		'{OP_NOP,        COND_UNUSED,  A_IGN,   1'b0},
		'{OP_NOP,        COND_BADORD,  A_ERR,   1'b0},
		// log2 of the removed distance
		'{OP_LOADA,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM16,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM8,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM4,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM2,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM1,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_SQR,        COND_LOOP,    A_SQRA,  1'b0},
		// log2 of the inserted distance
		'{OP_LOADB,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM16,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM8,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM4,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM2,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_NORM1,      COND_NEXT,    A_NONE,  1'b0},
		'{OP_SQR,        COND_LOOP,    A_SQRB,  1'b0},
		// gain = difference / k
		'{OP_DIVINIT,    COND_NEXT,    A_NONE,  1'b0},
		'{OP_DIVSTEP,    COND_LOOP,    A_DIV,   1'b0},
		'{OP_NOP,        COND_GZERO,   A_QUIET, 1'b0},
		// positive gain update
		'{OP_GAIN_BPOW,  COND_NEXT,    A_NONE,  1'b0},
		'{OP_MOM_LO,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_MOM_GAIN,   COND_NEXT,    A_NONE,  1'b0},
		'{OP_MOM_HI,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_SCL_LO,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_SCL_MAX,    COND_ALWAYS,  A_STEST, 1'b0},
		// quiet step decay
		'{OP_QUIET_BPOW, COND_NEXT,    A_NONE,  1'b0},
		'{OP_MOM_LO,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_MOM_HI,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_SCL_LO,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_SCL_HI,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_NOP,        COND_SCLZERO, A_QLIM,  1'b0},
		// stop test
		'{OP_T_CALC,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_CMP_LO,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_CMP_HI,     COND_NEXT,    A_NONE,  1'b0},
		'{OP_CMP_FIN,    COND_NEXT,    A_NONE,  1'b1},
		// terminal steps
		'{OP_QLIM,       COND_NEXT,    A_NONE,  1'b1},
		'{OP_RESTART,    COND_NEXT,    A_NONE,  1'b1},
		'{OP_NOP,        COND_NEXT,    A_NONE,  1'b1},
		'{OP_ERR,        COND_NEXT,    A_NONE,  1'b1}
	};

endpackage

// ===== rtl/ssc_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps
module ssc_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_hold,
	input  ssc_pkg::flags_t   flags,
	output ssc_pkg::ctl_t     ctl,
	output logic              busy,
	output logic              done,
	output ssc_pkg::pc_t      pc
);

	ssc_pkg::pc_t    pc_q;
	logic            busy_q;
	ssc_pkg::uword_t uw;
	logic            take;
	logic            en;

	always_comb begin
		if (pc_q < ssc_pkg::PC_W'(ssc_pkg::UCODE_LEN)) begin
			uw = ssc_pkg::UCODE[pc_q];
		end else begin
			uw = '{ssc_pkg::OP_NOP, ssc_pkg::COND_NEXT, ssc_pkg::A_NONE, 1'b1};
		end
	end

	always_comb begin
		case (uw.cond)
			ssc_pkg::COND_NEXT:    take = 1'b0;
			ssc_pkg::COND_ALWAYS:  take = 1'b1;
			ssc_pkg::COND_QUIET:   take = flags.cmd_quiet;
			ssc_pkg::COND_RESTART: take = flags.cmd_restart;
			ssc_pkg::COND_UNUSED:  take = flags.cmd_unused;
			ssc_pkg::COND_BADORD:  take = flags.bad_order;
			ssc_pkg::COND_LOOP:    take = flags.loop_more;
			ssc_pkg::COND_GZERO:   take = flags.gain_zero;
			ssc_pkg::COND_SCLZERO: take = flags.scale_zero;
			default:               take = 1'b0;
		endcase
	end

	// hold the final step while the previous result still waits
	assign en   = busy_q && !(uw.done && out_hold);
	assign done = en && uw.done;
	assign ctl  = '{start: start, en: en, op: uw.op};
	assign busy = busy_q;
	assign pc   = pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (en) begin
			if (uw.done) begin
				busy_q <= 1'b0;
			end else if (take) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ssc_datapath.sv =====
// Datapath: shared 32x32 multiplier, log and divide scratch registers, controller state
module ssc_datapath #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ssc_pkg::ctl_t    ctl,
	input  ssc_pkg::cfg_t    cfg,
	input  logic [1:0]       cmd,
	input  logic [31:0]      evict_dist,
	input  logic [31:0]      insert_dist,
	output ssc_pkg::flags_t  flags,
	output ssc_pkg::res_t    res
);

	localparam int FB = GAIN_FRAC_BITS;
	localparam int LW = FB + 5;
	localparam int CW = $clog2(LW);

	// event beat
	logic [1:0]    cmd_q;
	logic [31:0]   drem_q;
	logic [31:0]   dins_q;

	// scratch
	logic [31:0]   mant_q;
	logic [4:0]    expo_q;
	logic [FB-1:0] frac_q;
	logic [LW-1:0] la_q;
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] quo_q;
	logic [8:0]    rem_q;
	logic [63:0]   acc_q;
	logic [31:0]   t_q;
	logic [40:0]   cmpv_q;

	// controller state
	logic [39:0]   mom_q;
	logic [39:0]   scl_q;
	logic [31:0]   bpow_q;
	logic [15:0]   qcnt_q;

	logic [8:0]    k_eff;
	logic [31:0]   floor_eff;
	logic [31:0]   a_clip;
	logic [31:0]   b_clip;
	logic [LW-1:0] lb;
	logic [LW-1:0] diff;
	logic [16:0]   beta_c;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   prod;
	logic [39:0]   dec_hi;
	logic [39:0]   gain_ext;
	logic [9:0]    div_sh;
	logic          div_ge;
	logic [9:0]    div_sub;
	logic [40:0]   cmpv_d;
	logic [40:0]   mom_ext;

	assign k_eff     = (cfg.topk == '0) ? 9'd1 : cfg.topk;
	assign floor_eff = (cfg.dist_floor == '0) ? 32'd1 : cfg.dist_floor;
	assign a_clip    = (drem_q > floor_eff) ? drem_q : floor_eff;
	assign b_clip    = (dins_q > floor_eff) ? dins_q : floor_eff;
	assign lb        = {expo_q, frac_q};
	assign diff      = (la_q > lb) ? (la_q - lb) : '0;
	assign beta_c    = 17'd65536 - {1'b0, cfg.beta_m};
	assign gain_ext  = {{(40-LW){1'b0}}, quo_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.op)
			ssc_pkg::OP_SQR: begin
				mul_a = mant_q;
				mul_b = mant_q;
			end
			ssc_pkg::OP_GAIN_BPOW, ssc_pkg::OP_QUIET_BPOW: begin
				mul_a = bpow_q;
				mul_b = {16'b0, cfg.beta_m};
			end
			ssc_pkg::OP_MOM_LO: begin
				mul_a = mom_q[31:0];
				mul_b = {16'b0, cfg.beta_m};
			end
			ssc_pkg::OP_MOM_GAIN: begin
				mul_a = {15'b0, beta_c};
				mul_b = {{(32-LW){1'b0}}, quo_q};
			end
			ssc_pkg::OP_MOM_HI: begin
				mul_a = {24'b0, mom_q[39:32]};
				mul_b = {16'b0, cfg.beta_m};
			end
			ssc_pkg::OP_SCL_LO: begin
				mul_a = scl_q[31:0];
				mul_b = {16'b0, cfg.beta_s};
			end
			ssc_pkg::OP_SCL_HI, ssc_pkg::OP_SCL_MAX: begin
				mul_a = {24'b0, scl_q[39:32]};
				mul_b = {16'b0, cfg.beta_s};
			end
			ssc_pkg::OP_T_CALC: begin
				mul_a = cfg.threshold;
				mul_b = ~bpow_q;
			end
			ssc_pkg::OP_CMP_LO: begin
				mul_a = t_q;
				mul_b = scl_q[31:0];
			end
			ssc_pkg::OP_CMP_HI: begin
				mul_a = t_q;
				mul_b = {24'b0, scl_q[39:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// (x * beta) >> 16 rebuilt from the low partial product in acc and the top byte product
	assign dec_hi = acc_q[55:16] + {prod[23:0], 16'b0};

	assign div_sh  = {rem_q, quo_q[LW-1]};
	assign div_ge  = (div_sh >= {1'b0, k_eff});
	assign div_sub = div_sh - {1'b0, k_eff};

	assign cmpv_d  = {1'b0, prod[39:0]} + {9'b0, acc_q[63:32]};
	assign mom_ext = {1'b0, mom_q};

	always_comb begin
		res = '0;
		case (ctl.op)
			ssc_pkg::OP_CMP_FIN: res.stop = (mom_ext < cmpv_q)
				|| ((mom_ext == cmpv_q) && (acc_q[31:0] != '0));
			ssc_pkg::OP_QLIM:    res.stop = (qcnt_q > cfg.qlimit);
			ssc_pkg::OP_ERR:     res.error = 1'b1;
			default:             res = '0;
		endcase
	end

	assign flags = '{
		cmd_quiet:   (cmd_q == ssc_pkg::CMD_QUIET),
		cmd_restart: (cmd_q == ssc_pkg::CMD_RESTART),
		cmd_unused:  (cmd_q == ssc_pkg::CMD_UNUSED),
		bad_order:   (dins_q > drem_q),
		loop_more:   (cnt_q != '0),
		gain_zero:   (quo_q == '0),
		scale_zero:  (scl_q == '0)
	};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q  <= cmd;
			drem_q <= evict_dist;
			dins_q <= insert_dist;
		end
		if (ctl.en) begin
			case (ctl.op)
				ssc_pkg::OP_LOADA: begin
					mant_q <= a_clip;
					expo_q <= 5'd31;
					frac_q <= '0;
					cnt_q  <= CW'(FB - 1);
				end
				ssc_pkg::OP_LOADB: begin
					la_q   <= lb;
					mant_q <= b_clip;
					expo_q <= 5'd31;
					frac_q <= '0;
					cnt_q  <= CW'(FB - 1);
				end
				ssc_pkg::OP_NORM16: begin
					if (mant_q[31:16] == '0) begin
						mant_q <= {mant_q[15:0], 16'b0};
						expo_q <= expo_q - 5'd16;
					end
				end
				ssc_pkg::OP_NORM8: begin
					if (mant_q[31:24] == '0) begin
						mant_q <= {mant_q[23:0], 8'b0};
						expo_q <= expo_q - 5'd8;
					end
				end
				ssc_pkg::OP_NORM4: begin
					if (mant_q[31:28] == '0) begin
						mant_q <= {mant_q[27:0], 4'b0};
						expo_q <= expo_q - 5'd4;
					end
				end
				ssc_pkg::OP_NORM2: begin
					if (mant_q[31:30] == '0) begin
						mant_q <= {mant_q[29:0], 2'b0};
						expo_q <= expo_q - 5'd2;
					end
				end
				ssc_pkg::OP_NORM1: begin
					if (!mant_q[31]) begin
						mant_q <= {mant_q[30:0], 1'b0};
						expo_q <= expo_q - 5'd1;
					end
				end
				ssc_pkg::OP_SQR: begin
					// square the mantissa; a carry into bit 63 yields a one fraction bit
					if (prod[63]) begin
						frac_q <= {frac_q[FB-2:0], 1'b1};
						mant_q <= prod[63:32];
					end else begin
						frac_q <= {frac_q[FB-2:0], 1'b0};
						mant_q <= prod[62:31];
					end
					cnt_q <= cnt_q - 1'b1;
				end
				ssc_pkg::OP_DIVINIT: begin
					quo_q <= diff;
					rem_q <= '0;
					cnt_q <= CW'(LW - 1);
				end
				ssc_pkg::OP_DIVSTEP: begin
					rem_q <= div_ge ? div_sub[8:0] : div_sh[8:0];
					quo_q <= {quo_q[LW-2:0], div_ge};
					cnt_q <= cnt_q - 1'b1;
				end
				ssc_pkg::OP_MOM_LO, ssc_pkg::OP_SCL_LO, ssc_pkg::OP_CMP_LO: begin
					acc_q <= prod;
				end
				ssc_pkg::OP_MOM_GAIN: begin
					acc_q <= acc_q + prod;
				end
				ssc_pkg::OP_T_CALC: begin
					t_q <= prod[63:32];
				end
				ssc_pkg::OP_CMP_HI: begin
					cmpv_q <= cmpv_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mom_q  <= '0;
			scl_q  <= '0;
			bpow_q <= ssc_pkg::BPOW_ONE;
			qcnt_q <= '0;
		end else if (ctl.en) begin
			case (ctl.op)
				ssc_pkg::OP_GAIN_BPOW: begin
					qcnt_q <= '0;
					bpow_q <= prod[47:16];
				end
				ssc_pkg::OP_QUIET_BPOW: begin
					if (qcnt_q != 16'hFFFF) begin
						qcnt_q <= qcnt_q + 1'b1;
					end
					bpow_q <= prod[47:16];
				end
				ssc_pkg::OP_MOM_HI: begin
					mom_q <= dec_hi;
				end
				ssc_pkg::OP_SCL_HI: begin
					scl_q <= dec_hi;
				end
				ssc_pkg::OP_SCL_MAX: begin
					scl_q <= (dec_hi > gain_ext) ? dec_hi : gain_ext;
				end
				ssc_pkg::OP_RESTART: begin
					mom_q  <= '0;
					scl_q  <= '0;
					bpow_q <= ssc_pkg::BPOW_ONE;
					qcnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/adam_style_search_stop_controller_core.sv =====
// Each event kind takes its own path through the microcode (F = GAIN_FRAC_BITS): restart,
// unused command, distance order error, no change (shorter when scale is zero) and replacement.
// Each log takes F squarings on the one shared 32x32 multiplier; the divide by k yields F + 5 quotient bits.
// One event at a time; a new beat is taken the cycle after the result register loads.
// Reset clears the state to momentum 0, scale 0, beta power one, quiet count 0; registers to defaults.
module adam_style_search_stop_controller_core #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] evict_dist,
	input  logic [31:0] insert_dist,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        stop,
	output logic        error
);

	ssc_pkg::cfg_t   cfg_q;
	ssc_pkg::ctl_t   ctl;
	ssc_pkg::flags_t flags;
	ssc_pkg::res_t   res;
	ssc_pkg::pc_t    seq_pc;
	logic            seq_busy;
	logic            seq_done;
	logic            start;
	logic            out_hold;
	logic            out_valid_q;
	logic            stop_q;
	logic            error_q;

	assign in_ready  = !seq_busy;
	assign start     = in_valid && in_ready;
	assign out_hold  = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign stop      = stop_q;
	assign error     = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beta_m     <= ssc_pkg::RST_BETA_M;
			cfg_q.beta_s     <= ssc_pkg::RST_BETA_S;
			cfg_q.threshold  <= ssc_pkg::RST_THRESHOLD;
			cfg_q.topk       <= ssc_pkg::RST_TOPK;
			cfg_q.dist_floor <= ssc_pkg::RST_FLOOR;
			cfg_q.qlimit     <= ssc_pkg::RST_QLIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				ssc_pkg::CFG_BETA_M:    cfg_q.beta_m     <= cfg_data[15:0];
				ssc_pkg::CFG_BETA_S:    cfg_q.beta_s     <= cfg_data[15:0];
				ssc_pkg::CFG_THRESHOLD: cfg_q.threshold  <= cfg_data;
				ssc_pkg::CFG_TOPK:      cfg_q.topk       <= cfg_data[8:0];
				ssc_pkg::CFG_FLOOR:     cfg_q.dist_floor <= cfg_data;
				ssc_pkg::CFG_QLIMIT:    cfg_q.qlimit     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	ssc_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_hold (out_hold),
		.flags    (flags),
		.ctl      (ctl),
		.busy     (seq_busy),
		.done     (seq_done),
		.pc       (seq_pc)
	);

	ssc_datapath #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.evict_dist  (evict_dist),
		.insert_dist (insert_dist),
		.flags       (flags),
		.res         (res)
	);

	// load the result beat on the final step, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			stop_q  <= res.stop;
			error_q <= res.error;
		end
	end

`ifndef SYNTHESIS
	a_stop_excl_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stop && error))
		else $error("stop and error raised on the same result beat");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(seq_busy))
		else $error("result beat appeared without an event in progress");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		seq_busy |-> (seq_pc < ssc_pkg::PC_W'(ssc_pkg::UCODE_LEN)))
		else $error("step counter left the microcode program");
`endif

endmodule

// ===== test/tb_adam_style_search_stop_controller_core.sv =====
// Testbench for the search stop controller: directed and random events checked against a predictor
`timescale 1ns / 100ps

module tb_adam_style_search_stop_controller_core;

	localparam int FRAC_BITS = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [31:0] evict_dist = '0;
	logic [31:0] insert_dist = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        stop;
	logic        error;

	// predictor copy of the registers and the controller state
	logic [15:0] cfg_bm, cfg_bs, cfg_qlim;
	logic [31:0] cfg_thr, cfg_floor;
	logic [8:0]  cfg_k;
	logic [39:0] st_mom, st_scl;
	logic [31:0] st_bpow;
	logic [15:0] st_qcnt;

	ssc_pkg::res_t pending_verdicts[$];
	int            mismatch_count = 0;
	bit            idle_on = 1'b1;

	adam_style_search_stop_controller_core #(
		.GAIN_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.evict_dist(evict_dist),
		.insert_dist(insert_dist),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stop(stop),
		.error(error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(64'd40_000_000);
		$display("Verification failed");
		$finish;
	end

	function automatic void clear_controller();
		st_mom = '0;
		st_scl = '0;
		st_bpow = ssc_pkg::BPOW_ONE;
		st_qcnt = '0;
	endfunction

	function automatic void reset_predictor();
		cfg_bm = ssc_pkg::RST_BETA_M;
		cfg_bs = ssc_pkg::RST_BETA_S;
		cfg_thr = ssc_pkg::RST_THRESHOLD;
		cfg_k = ssc_pkg::RST_TOPK;
		cfg_floor = ssc_pkg::RST_FLOOR;
		cfg_qlim = ssc_pkg::RST_QLIMIT;
		clear_controller();
	endfunction

	// integer part from the msb position, fraction by repeated squaring of the mantissa
	function automatic logic [31:0] log2_gain_units(input logic [31:0] x);
		int top;
		int i;
		logic [63:0] mant;
		logic [63:0] sq;
		logic [31:0] frac;
		top = 0;
		frac = '0;
		for (i = 0; i < 32; i++)
			if (x[i]) top = i;
		mant = {32'b0, x << (31 - top)};
		for (i = 0; i < FRAC_BITS; i++) begin
			sq = mant * mant;
			if (sq[63]) begin
				frac = {frac[30:0], 1'b1};
				mant = sq >> 32;
			end else begin
				frac = {frac[30:0], 1'b0};
				mant = sq >> 31;
			end
		end
		return (32'(top) << FRAC_BITS) | frac;
	endfunction

	function automatic bit progress_stalled();
		logic [63:0]  corr_prod;
		logic [31:0]  t;
		logic [127:0] lhs, rhs;
		if (st_scl == '0) return 1'b0;
		corr_prod = 64'(cfg_thr) * 64'(ssc_pkg::BPOW_ONE - st_bpow);
		t = corr_prod[63:32];
		lhs = {st_mom, 32'b0};
		rhs = 128'(t) * 128'(st_scl);
		return lhs < rhs;
	endfunction

	function automatic bit apply_quiet_step();
		if (st_qcnt != 16'hFFFF) st_qcnt = st_qcnt + 16'd1;
		st_bpow = 32'((64'(st_bpow) * 64'(cfg_bm)) >> 16);
		st_mom = 40'((64'(st_mom) * 64'(cfg_bm)) >> 16);
		st_scl = 40'((64'(st_scl) * 64'(cfg_bs)) >> 16);
		if (st_scl == '0) return st_qcnt > cfg_qlim;
		return progress_stalled();
	endfunction

	function automatic bit apply_gain(input logic [31:0] g);
		logic [63:0] decayed;
		st_qcnt = '0;
		st_bpow = 32'((64'(st_bpow) * 64'(cfg_bm)) >> 16);
		st_mom = 40'((64'(cfg_bm) * 64'(st_mom) + (64'd65536 - 64'(cfg_bm)) * 64'(g)) >> 16);
		decayed = (64'(cfg_bs) * 64'(st_scl)) >> 16;
		st_scl = 40'((decayed > 64'(g)) ? decayed : 64'(g));
		return progress_stalled();
	endfunction

	function automatic ssc_pkg::res_t predict_verdict(input ssc_pkg::cmd_t c,
			input logic [31:0] rem, input logic [31:0] ins);
		ssc_pkg::res_t r;
		logic [31:0] fl, a, b, la, lb, g;
		logic [8:0] k;
		r = '0;
		case (c)
			ssc_pkg::CMD_QUIET: r.stop = apply_quiet_step();
			ssc_pkg::CMD_REPLACE: begin
				if (ins > rem) begin
					r.error = 1'b1;
				end else begin
					fl = (cfg_floor != '0) ? cfg_floor : 32'd1;
					k = (cfg_k != '0) ? cfg_k : 9'd1;
					a = (rem > fl) ? rem : fl;
					b = (ins > fl) ? ins : fl;
					la = log2_gain_units(a);
					lb = log2_gain_units(b);
					g = (la > lb) ? (la - lb) / 32'(k) : 32'd0;
					if (g != '0) r.stop = apply_gain(g);
					else r.stop = apply_quiet_step();
				end
			end
			ssc_pkg::CMD_RESTART: clear_controller();
			default: ;
		endcase
		return r;
	endfunction

	function automatic int gap_length();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : verdict_monitor
		ssc_pkg::res_t want;
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("verdict beat with no event pending: stop %0b error %0b", stop, error);
					mismatch_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (stop !== want.stop) begin
						$error("stop: expected %0b, got %0b", want.stop, stop);
						mismatch_count++;
					end
					if (error !== want.error) begin
						$error("error: expected %0b, got %0b", want.error, error);
						mismatch_count++;
					end
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = gap_length();
			end
		end
	end

	task automatic send_event(input ssc_pkg::cmd_t c, input logic [31:0] rem,
			input logic [31:0] ins);
		int gap;
		ssc_pkg::res_t verdict;
		gap = gap_length();
		@(posedge clk);
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		evict_dist <= rem;
		insert_dist <= ins;
		do @(posedge clk); while (!in_ready);
		verdict = predict_verdict(c, rem, ins);
		pending_verdicts = {pending_verdicts, verdict};
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ssc_pkg::CFG_BETA_M:    cfg_bm = val[15:0];
			ssc_pkg::CFG_BETA_S:    cfg_bs = val[15:0];
			ssc_pkg::CFG_THRESHOLD: cfg_thr = val;
			ssc_pkg::CFG_TOPK:      cfg_k = val[8:0];
			ssc_pkg::CFG_FLOOR:     cfg_floor = val;
			ssc_pkg::CFG_QLIMIT:    cfg_qlim = val[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] bm, input logic [15:0] bs,
			input logic [31:0] thr, input logic [8:0] k, input logic [31:0] fl,
			input logic [15:0] ql);
		wait_drained();
		write_reg(ssc_pkg::CFG_BETA_M, 32'(bm));
		write_reg(ssc_pkg::CFG_BETA_S, 32'(bs));
		write_reg(ssc_pkg::CFG_THRESHOLD, thr);
		write_reg(ssc_pkg::CFG_TOPK, 32'(k));
		write_reg(ssc_pkg::CFG_FLOOR, fl);
		write_reg(ssc_pkg::CFG_QLIMIT, 32'(ql));
	endtask

	task automatic test_event_kinds();
		send_event(ssc_pkg::CMD_QUIET, 32'h0, 32'h0);
		send_event(ssc_pkg::CMD_REPLACE, 32'hFFFF_FFFF, 32'h0);
		send_event(ssc_pkg::CMD_REPLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(ssc_pkg::CMD_REPLACE, 32'h0, 32'hFFFF_FFFF);
		send_event(ssc_pkg::CMD_REPLACE, 32'h0, 32'h0);
		send_event(ssc_pkg::CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(ssc_pkg::CMD_RESTART, 32'hFFFF_FFFF, 32'h0);
		send_event(ssc_pkg::CMD_REPLACE, 32'h0001_0000, 32'h0000_8000);
		send_event(ssc_pkg::CMD_QUIET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_quiet_rule();
		apply_settings(ssc_pkg::RST_BETA_M, ssc_pkg::RST_BETA_S, ssc_pkg::RST_THRESHOLD,
			ssc_pkg::RST_TOPK, ssc_pkg::RST_FLOOR, 16'd0);
		send_event(ssc_pkg::CMD_RESTART, 32'h0, 32'h0);
		send_event(ssc_pkg::CMD_QUIET, 32'h0, 32'h0);
		send_event(ssc_pkg::CMD_QUIET, 32'h0, 32'h0);
		// a tiny scale decay truncates scale back to zero within two quiet steps
		apply_settings(ssc_pkg::RST_BETA_M, 16'd1, ssc_pkg::RST_THRESHOLD,
			ssc_pkg::RST_TOPK, ssc_pkg::RST_FLOOR, 16'd0);
		send_event(ssc_pkg::CMD_REPLACE, 32'hFFFF_FFFF, 32'h1);
		send_event(ssc_pkg::CMD_QUIET, 32'h0, 32'h0);
		send_event(ssc_pkg::CMD_QUIET, 32'h0, 32'h0);
		send_event(ssc_pkg::CMD_QUIET, 32'h0, 32'h0);
		apply_settings(ssc_pkg::RST_BETA_M, ssc_pkg::RST_BETA_S, ssc_pkg::RST_THRESHOLD,
			ssc_pkg::RST_TOPK, ssc_pkg::RST_FLOOR, 16'hFFFF);
		send_event(ssc_pkg::CMD_RESTART, 32'h0, 32'h0);
		send_event(ssc_pkg::CMD_QUIET, 32'h0, 32'h0);
	endtask

	task automatic test_clamped_settings();
		// zero k and zero floor behave as one
		apply_settings(16'd1, ssc_pkg::RST_BETA_S, 32'hFFFF_FFFF, 9'd0, 32'd0,
			ssc_pkg::RST_QLIMIT);
		send_event(ssc_pkg::CMD_REPLACE, 32'h8000_0000, 32'h2);
		send_event(ssc_pkg::CMD_REPLACE, 32'h3, 32'h0);
		apply_settings(16'hFFFF, 16'hFFFF, 32'd1, 9'd256, 32'hFFFF_FFFF, ssc_pkg::RST_QLIMIT);
		send_event(ssc_pkg::CMD_REPLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_event(ssc_pkg::CMD_REPLACE, 32'hFFFF_FFFF, 32'h0);
	endtask

	function automatic logic [31:0] pick_setting(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] typical_hi);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, typical_hi);
		endcase
	endfunction

	task automatic send_random_event();
		int r;
		logic [31:0] rem, ins, lo, hi;
		logic [63:0] span;
		r = $urandom_range(0, 99);
		rem = $urandom >> $urandom_range(0, 31);
		if ($urandom_range(0, 1)) begin
			ins = rem - (rem >> $urandom_range(1, 16));
		end else begin
			span = 64'(rem) + 64'd1;
			ins = rem - 32'(64'($urandom) % span);
		end
		if (r < 30) begin
			send_event(ssc_pkg::CMD_QUIET, $urandom, $urandom);
		end else if (r < 82) begin
			send_event(ssc_pkg::CMD_REPLACE, rem, ins);
		end else if (r < 90) begin
			// inserted beyond removed
			lo = $urandom;
			hi = $urandom;
			if (lo > hi) {lo, hi} = {hi, lo};
			if (lo == hi) begin
				if (hi != '0) lo = hi - 32'd1;
				else hi = 32'd1;
			end
			send_event(ssc_pkg::CMD_REPLACE, lo, hi);
		end else if (r < 95) begin
			send_event(ssc_pkg::CMD_RESTART, $urandom, $urandom);
		end else begin
			send_event(ssc_pkg::CMD_UNUSED, $urandom, $urandom);
		end
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: apply_settings(ssc_pkg::RST_BETA_M, ssc_pkg::RST_BETA_S,
					ssc_pkg::RST_THRESHOLD, ssc_pkg::RST_TOPK,
					ssc_pkg::RST_FLOOR, ssc_pkg::RST_QLIMIT);
				1: apply_settings(16'd1, 16'd1, 32'd1, 9'd1, 32'd1, 16'd0);
				2: apply_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 9'd256, 32'd1, 16'hFFFF);
				default: apply_settings(
					16'(pick_setting(1, 65535, 65535)),
					16'(pick_setting(1, 65535, 65535)),
					pick_setting(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
					9'(pick_setting(1, 256, 16)),
					pick_setting(1, 32'hFFFF_FFFF, 32'h0002_0000),
					16'(pick_setting(0, 65535, 40)));
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			for (n = 0; n < 75; n++) send_random_event();
		end
		idle_on = 1'b1;
	endtask

	// hold scale at zero and run the quiet count past a small limit
	task automatic test_quiet_count();
		int n;
		apply_settings(ssc_pkg::RST_BETA_M, ssc_pkg::RST_BETA_S, ssc_pkg::RST_THRESHOLD,
			ssc_pkg::RST_TOPK, ssc_pkg::RST_FLOOR, 16'd40);
		idle_on = 1'b0;
		send_event(ssc_pkg::CMD_RESTART, 32'h0, 32'h0);
		for (n = 0; n < 45; n++) send_event(ssc_pkg::CMD_QUIET, $urandom, $urandom);
		idle_on = 1'b1;
	endtask

	initial begin
		int n;
		reset_predictor();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_event_kinds();
		test_quiet_rule();
		test_clamped_settings();
		test_random_traffic();
		test_quiet_count();
		for (n = 0; n < 20000 && pending_verdicts.size() != 0; n++) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", pending_verdicts.size());
			mismatch_count++;
		end
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
